@@ hdl/mcc_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mcc_pkg
// Shared widths, register indexes and table codes for the minimum coin
// change unit.
// ----------------------------------------------------------------------------
package mcc_pkg;

  // field widths
  localparam int AMOUNT_W    = 10;
  localparam int COINS_W     = 10;
  localparam int COUNT_W     = 3;
  localparam int VALUE_W     = 10;
  localparam int ENTRY_W     = 11;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 10;
  localparam int IN_TDATA_W  = 16;
  localparam int OUT_TDATA_W = 16;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_COIN_COUNT   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COIN_VALUE_0 = 3'd1;
  localparam int                   NUM_COIN_REGS    = 6;

  // table entry marking an amount that cannot be formed
  localparam logic [ENTRY_W-1:0] UNREACH = 11'h7FF;

  typedef logic [ENTRY_W-1:0] entry_t;

endpackage : mcc_pkg
`default_nettype wire

@@ hdl/min_coin_change_unit.sv @@
`timescale 1ns / 1ps
`default_nettype none
// Per word: the count table is seeded for amounts 0 to amount, then each coin in use is
// picked in turn and, when its value v is nonzero and <= amount, swept from v up to amount
// and drained; then the result word is loaded.
// One word is worked at a time; the next word can be taken the cycle after the result loads.
// Reset (rst_n, synchronous): coin_count = 1, all coin values = 1, channels idle.
// The count table needs no clearing: every query rewrites what it reads.
// ----------------------------------------------------------------------------
// min_coin_change_unit
// Fewest coins summing exactly to a requested amount, built bottom-up in a
// block-RAM count table, one coin pass after another.
// ----------------------------------------------------------------------------
module min_coin_change_unit
  import mcc_pkg::*;
#(
  parameter int MAX_AMOUNT = 1024,
  parameter int NUM_COINS  = 6
) (
  input  wire                    clk,
  input  wire                    rst_n,
  // config write channel
  input  wire                    cfg_valid,
  output logic                   cfg_ready,
  input  wire [CFG_IDX_W-1:0]    cfg_index,
  input  wire [CFG_DATA_W-1:0]   cfg_data,
  // query stream
  input  wire                    in_tvalid,
  output logic                   in_tready,
  input  wire [IN_TDATA_W-1:0]   in_tdata,   // [9:0] amount
  // result stream
  output logic                   out_tvalid,
  input  wire                    out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,  // [9:0] min_coins
  output logic                   out_tuser   // [0] no_solution
);

  localparam int AW = (MAX_AMOUNT > 1) ? $clog2(MAX_AMOUNT) : 1;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_INIT  = 3'd1;
  localparam logic [2:0] ST_NEXT  = 3'd2;
  localparam logic [2:0] ST_RUN   = 3'd3;
  localparam logic [2:0] ST_DRAIN = 3'd4;
  localparam logic [2:0] ST_RES   = 3'd5;

  // config registers
  logic [COUNT_W-1:0] coin_count_r;
  logic [VALUE_W-1:0] coin_value_r [NUM_COINS];

  // control
  logic [2:0]          state_r, state_nxt;
  logic [AMOUNT_W-1:0] amount_r, amount_nxt;
  logic                big_r, big_nxt;
  logic [AMOUNT_W-1:0] a_r, a_nxt;
  logic [VALUE_W-1:0]  v_r, v_nxt;
  logic [COUNT_W-1:0]  coin_idx_r, coin_idx_nxt;

  // sweep pipeline
  logic                p1_valid_r;
  logic [AMOUNT_W-1:0] p1_addr_r;
  logic                fwd_hit_r;
  entry_t              fwd_data_r;

  // table memories (mirrored so two entries can be read per cycle)
  entry_t mem_prev [0:MAX_AMOUNT-1];
  entry_t mem_cur  [0:MAX_AMOUNT-1];
  entry_t rd_prev_r, rd_cur_r;

  // output register
  logic               out_valid_r;
  logic [COINS_W-1:0] out_coins_r;
  logic               out_nosol_r;

  logic [COUNT_W-1:0]  used;
  logic [VALUE_W-1:0]  sel_value;
  logic                issue;
  logic [AMOUNT_W-1:0] prev_addr;
  logic [AW-1:0]       rd_prev_addr, rd_cur_addr, wr_addr;
  entry_t              prev_val, cand, wr_data;
  logic                improve, wr_en;
  logic                in_acc, out_load;

  assign cfg_ready  = 1'b1;
  assign in_tready  = (state_r == ST_IDLE);
  assign in_acc     = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_TDATA_W-COINS_W){1'b0}}, out_coins_r};
  assign out_tuser  = out_nosol_r;

  // config writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coin_count_r <= COUNT_W'(1);
      for (int i = 0; i < NUM_COINS; i++) coin_value_r[i] <= VALUE_W'(1);
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == REG_COIN_COUNT) coin_count_r <= cfg_data[COUNT_W-1:0];
      for (int i = 0; i < NUM_COINS; i++) begin
        if (i < NUM_COIN_REGS && cfg_index == REG_COIN_VALUE_0 + CFG_IDX_W'(i))
          coin_value_r[i] <= cfg_data[VALUE_W-1:0];
      end
    end
  end

  // coins in use, and the value of the current coin
  always_comb begin
    used = (coin_count_r > COUNT_W'(NUM_COINS)) ? COUNT_W'(NUM_COINS) : coin_count_r;
    sel_value = '0;
    for (int i = 0; i < NUM_COINS; i++) begin
      if (coin_idx_r == COUNT_W'(i)) sel_value = coin_value_r[i];
    end
  end

  // sweep step: relax entry a from entry a - v
  always_comb begin
    issue     = (state_r == ST_RUN);
    prev_addr = a_r - v_r;
    prev_val  = fwd_hit_r ? fwd_data_r : rd_prev_r;
    cand      = prev_val + ENTRY_W'(1);
    improve   = p1_valid_r && (prev_val != UNREACH) && (cand < rd_cur_r);
    rd_prev_addr = AW'(prev_addr);
    rd_cur_addr  = issue ? AW'(a_r) : AW'(amount_r);
    if (state_r == ST_INIT) begin
      wr_en   = 1'b1;
      wr_addr = AW'(a_r);
      wr_data = (a_r == '0) ? '0 : UNREACH;
    end else begin
      wr_en   = improve;
      wr_addr = AW'(p1_addr_r);
      wr_data = cand;
    end
  end

  // table memories
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_prev[wr_addr] <= wr_data;
      mem_cur[wr_addr]  <= wr_data;
    end
    rd_prev_r <= mem_prev[rd_prev_addr];
    rd_cur_r  <= mem_cur[rd_cur_addr];
  end

  // pipeline and bypass of a same-cycle write to the entry being read
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_valid_r <= 1'b0;
      fwd_hit_r  <= 1'b0;
    end else begin
      p1_valid_r <= issue;
      fwd_hit_r  <= issue && improve && (prev_addr == p1_addr_r);
    end
    p1_addr_r  <= a_r;
    fwd_data_r <= cand;
  end

  // sequencer
  always_comb begin
    state_nxt    = state_r;
    amount_nxt   = amount_r;
    big_nxt      = big_r;
    a_nxt        = a_r;
    v_nxt        = v_r;
    coin_idx_nxt = coin_idx_r;
    out_load     = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          amount_nxt   = in_tdata[AMOUNT_W-1:0];
          big_nxt      = (32'(in_tdata[AMOUNT_W-1:0]) >= 32'(MAX_AMOUNT));
          a_nxt        = '0;
          coin_idx_nxt = '0;
          state_nxt    = (32'(in_tdata[AMOUNT_W-1:0]) >= 32'(MAX_AMOUNT)) ? ST_RES : ST_INIT;
        end
      end
      ST_INIT: begin
        a_nxt = a_r + AMOUNT_W'(1);
        if (a_r == amount_r) state_nxt = ST_NEXT;
      end
      ST_NEXT: begin
        if (coin_idx_r >= used) begin
          state_nxt = ST_RES;
        end else begin
          coin_idx_nxt = coin_idx_r + COUNT_W'(1);
          if (sel_value != '0 && sel_value <= amount_r) begin
            v_nxt     = sel_value;
            a_nxt     = sel_value;
            state_nxt = ST_RUN;
          end
        end
      end
      ST_RUN: begin
        a_nxt = a_r + AMOUNT_W'(1);
        if (a_r == amount_r) state_nxt = ST_DRAIN;
      end
      ST_DRAIN: state_nxt = ST_NEXT;
      ST_RES: begin
        if (!out_valid_r || out_tready) begin
          out_load  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      coin_idx_r <= '0;
    end else begin
      state_r    <= state_nxt;
      coin_idx_r <= coin_idx_nxt;
    end
    amount_r <= amount_nxt;
    big_r    <= big_nxt;
    a_r      <= a_nxt;
    v_r      <= v_nxt;
  end

  // result word register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
    if (out_load) begin
      if (big_r || rd_cur_r == UNREACH) begin
        out_coins_r <= '0;
        out_nosol_r <= 1'b1;
      end else begin
        out_coins_r <= rd_cur_r[COINS_W-1:0];
        out_nosol_r <= 1'b0;
      end
    end
  end

endmodule : min_coin_change_unit
`default_nettype wire
